// ===== design/cylindrical_sor_node_relax_defines.svh =====
// assertion macros shared by the cylindrical relaxation node design
`ifndef CYLINDRICAL_SOR_NODE_RELAX_DEFINES_SVH
`define CYLINDRICAL_SOR_NODE_RELAX_DEFINES_SVH

// condition holds in the same cycle
`define CSOR_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition holds in the next cycle
`define CSOR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/csor_pkg.sv =====
// types, constants and step program of the cylindrical relaxation node design
`timescale 1ns / 1ps
package csor_pkg;

  localparam int VW     = 48;
  localparam int FB     = 24;
  localparam int IDX_W  = 12;
  localparam int NODES  = 1 << IDX_W;
  localparam int CNT_W  = IDX_W + 1;
  localparam int RF_W   = 26;
  localparam int CFG_W  = VW;
  localparam int CIDX_W = 2;

  localparam int IN_BITS  = IDX_W + 1 + 3 * VW + 4 * (VW - 1) + 1;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = VW + 2;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [1:0] REQ_WRITE    = 2'd0;
  localparam logic [1:0] REQ_RELAX    = 2'd1;
  localparam logic [1:0] REQ_READ     = 2'd2;
  localparam logic [1:0] REQ_READ_ALT = 2'd3;

  localparam logic [CIDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_NODES   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DENSITY = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_RELAX   = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  typedef enum logic [4:0] {
    SRC_OWN, SRC_PRM, SRC_PRP, SRC_PZM, SRC_PZP,
    SRC_DRM, SRC_DRP, SRC_DZM, SRC_DZP,
    SRC_IMP, SRC_RAD, SRC_ONE, SRC_DS, SRC_RF,
    SRC_SR, SRC_SZ, SRC_ACC, SRC_DEN, SRC_X, SRC_Y, SRC_E
  } src_t;

  typedef enum logic [2:0] {
    DST_SR, DST_SZ, DST_ACC, DST_DEN, DST_X, DST_Y, DST_E, DST_RES
  } dst_t;

  typedef struct packed {
    alu_op_t op;
    src_t    a;
    src_t    b;
    dst_t    dst;
  } step_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } alu_stat_t;

  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] STEP_EST   = 6'd30;
  localparam logic [STEP_W-1:0] STEP_RELAX = 6'd31;
  localparam logic [STEP_W-1:0] STEP_LAST  = 6'd33;

  // estimate program, then the over-relaxation tail
  function automatic step_t step_rom(input logic [STEP_W-1:0] s);
    step_t r;
    case (s)
      6'd0:    r = '{OP_ADD, SRC_DRM, SRC_DRP, DST_SR};
      6'd1:    r = '{OP_ADD, SRC_DZM, SRC_DZP, DST_SZ};
      6'd2:    r = '{OP_MUL, SRC_DS,  SRC_IMP, DST_ACC};
      6'd3:    r = '{OP_SUB, SRC_PRP, SRC_PRM, DST_X};
      6'd4:    r = '{OP_DIV, SRC_X,   SRC_SR,  DST_X};
      6'd5:    r = '{OP_DIV, SRC_X,   SRC_RAD, DST_X};
      6'd6:    r = '{OP_ADD, SRC_ACC, SRC_X,   DST_ACC};
      6'd7:    r = '{OP_DIV, SRC_PRP, SRC_DRP, DST_X};
      6'd8:    r = '{OP_DIV, SRC_PRM, SRC_DRM, DST_Y};
      6'd9:    r = '{OP_ADD, SRC_X,   SRC_Y,   DST_X};
      6'd10:   r = '{OP_ADD, SRC_X,   SRC_X,   DST_X};
      6'd11:   r = '{OP_DIV, SRC_X,   SRC_SR,  DST_X};
      6'd12:   r = '{OP_ADD, SRC_ACC, SRC_X,   DST_ACC};
      6'd13:   r = '{OP_DIV, SRC_PZP, SRC_DZP, DST_X};
      6'd14:   r = '{OP_DIV, SRC_PZM, SRC_DZM, DST_Y};
      6'd15:   r = '{OP_ADD, SRC_X,   SRC_Y,   DST_X};
      6'd16:   r = '{OP_ADD, SRC_X,   SRC_X,   DST_X};
      6'd17:   r = '{OP_DIV, SRC_X,   SRC_SZ,  DST_X};
      6'd18:   r = '{OP_ADD, SRC_ACC, SRC_X,   DST_ACC};
      6'd19:   r = '{OP_DIV, SRC_ONE, SRC_DRM, DST_X};
      6'd20:   r = '{OP_DIV, SRC_ONE, SRC_DRP, DST_Y};
      6'd21:   r = '{OP_ADD, SRC_X,   SRC_Y,   DST_X};
      6'd22:   r = '{OP_ADD, SRC_X,   SRC_X,   DST_X};
      6'd23:   r = '{OP_DIV, SRC_X,   SRC_SR,  DST_DEN};
      6'd24:   r = '{OP_DIV, SRC_ONE, SRC_DZP, DST_X};
      6'd25:   r = '{OP_DIV, SRC_ONE, SRC_DZM, DST_Y};
      6'd26:   r = '{OP_ADD, SRC_X,   SRC_Y,   DST_X};
      6'd27:   r = '{OP_ADD, SRC_X,   SRC_X,   DST_X};
      6'd28:   r = '{OP_DIV, SRC_X,   SRC_SZ,  DST_X};
      6'd29:   r = '{OP_ADD, SRC_DEN, SRC_X,   DST_DEN};
      6'd30:   r = '{OP_DIV, SRC_ACC, SRC_DEN, DST_E};
      6'd31:   r = '{OP_SUB, SRC_E,   SRC_OWN, DST_X};
      6'd32:   r = '{OP_MUL, SRC_RF,  SRC_X,   DST_X};
      6'd33:   r = '{OP_ADD, SRC_X,   SRC_OWN, DST_RES};
      default: r = '{OP_ADD, SRC_X,   SRC_OWN, DST_RES};
    endcase
    return r;
  endfunction

endpackage

// ===== design/csor_alu.sv =====
// shared saturating fixed-point unit: add, subtract, bit-serial multiply and divide
`timescale 1ns / 1ps
module csor_alu (
  input  logic                   clk,
  input  logic                   rst,
  input  csor_pkg::alu_ctl_t     ctl,
  input  logic [csor_pkg::VW-1:0] a,
  input  logic [csor_pkg::VW-1:0] b,
  output csor_pkg::alu_stat_t    stat,
  output logic [csor_pkg::VW-1:0] result
);
  import csor_pkg::*;

  localparam int MW = 2 * VW;
  localparam int DW = VW + FB;
  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] mag_a, mag_b;
  logic          neg_ab;
  logic [VW:0]   ext_a, ext_b, sum;
  logic [VW-1:0] sum_sat;
  logic          sum_ovf;

  logic          busy, done, sat, is_div, neg;
  logic [CW-1:0] cnt;
  logic [VW-1:0] mx, my, dd, rem;
  logic [MW-1:0] macc;
  logic [DW-1:0] dn, q;

  logic [VW:0]   remsh, remsub;
  logic          ge;
  logic [VW-1:0] lim, fin_mag, fin_val;
  logic          fin_over;

  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  assign mag_a  = a[VW-1] ? (~a + 1'b1) : a;
  assign mag_b  = b[VW-1] ? (~b + 1'b1) : b;
  assign neg_ab = a[VW-1] ^ b[VW-1];

  assign ext_a   = {a[VW-1], a};
  assign ext_b   = {b[VW-1], b};
  assign sum     = (ctl.op == OP_SUB) ? (ext_a - ext_b) : (ext_a + ext_b);
  assign sum_ovf = sum[VW] != sum[VW-1];
  assign sum_sat = sum_ovf ? (sum[VW] ? VMIN : VMAX) : sum[VW-1:0];

  // one quotient bit per cycle
  assign remsh  = {rem, dn[DW-1]};
  assign ge     = remsh >= {1'b0, dd};
  assign remsub = remsh - {1'b0, dd};

  // magnitude limit depends on the sign of the result
  assign lim = neg ? VMIN : VMAX;

  always_comb begin
    if (is_div) begin
      fin_over = (|q[DW-1:VW]) || (q[VW-1:0] > lim);
      fin_mag  = fin_over ? lim : q[VW-1:0];
    end else begin
      fin_over = (|macc[MW-1:FB+VW]) || (macc[FB+VW-1:FB] > lim);
      fin_mag  = fin_over ? lim : macc[FB+VW-1:FB];
    end
    fin_val = (neg && fin_mag != '0) ? (~fin_mag + 1'b1) : fin_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (ctl.start) begin
          case (ctl.op)
            OP_ADD, OP_SUB: begin
              result <= sum_sat;
              sat    <= sum_ovf;
              done   <= 1'b1;
            end
            OP_MUL: begin
              busy   <= 1'b1;
              is_div <= 1'b0;
              neg    <= neg_ab;
              cnt    <= CW'(VW);
              mx     <= mag_a;
              my     <= mag_b;
              macc   <= '0;
            end
            OP_DIV: begin
              if (mag_a == '0) begin
                result <= '0;
                sat    <= 1'b0;
                done   <= 1'b1;
              end else if (mag_b == '0) begin
                result <= a[VW-1] ? VMIN : VMAX;
                sat    <= 1'b1;
                done   <= 1'b1;
              end else begin
                busy   <= 1'b1;
                is_div <= 1'b1;
                neg    <= neg_ab;
                cnt    <= CW'(DW);
                dn     <= {mag_a, {FB{1'b0}}};
                dd     <= mag_b;
                rem    <= '0;
                q      <= '0;
              end
            end
            default: begin
              done <= 1'b1;
            end
          endcase
        end
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (is_div) begin
          rem <= ge ? remsub[VW-1:0] : remsh[VW-1:0];
          q   <= {q[DW-2:0], ge};
          dn  <= {dn[DW-2:0], 1'b0};
        end else begin
          macc <= {macc[MW-2:0], 1'b0} + (my[VW-1] ? {{VW{1'b0}}, mx} : {MW{1'b0}});
          my   <= {my[VW-2:0], 1'b0};
        end
      end else begin
        busy   <= 1'b0;
        done   <= 1'b1;
        result <= fin_val;
        sat    <= fin_over;
      end
    end
  end

  assign stat = '{busy: busy, done: done, sat: sat};

endmodule

// ===== design/cylindrical_sor_node_relax.sv =====
// top level: cylindrical r-z relaxation node engine with grid storage and sequencer
`timescale 1ns / 1ps
// Holds up to 4096 grid nodes (potential, impurity, radius, four spacings, fixed and
// depleted marks) in on-chip memories and serves one item at a time. tuser carries the
// request: 0 writes a node, 1 relaxes it, 2 or 3 reads it; every item returns one
// result. After reset the depleted marks are cleared by a sweep over every entry,
// during which no item is accepted. A write or read item passes through the look-up
// and own-read states before its result is shown. A relax item reads the node and its
// four neighbors, finds the node's column with a bit-serial remainder, then runs a
// 31-step program (up to 34 steps with over-relaxation) through one shared saturating
// unit, whose multiplies and divides work one bit per cycle. With 15 divides and up to
// 2 multiplies, a relax item spends almost all of its time in the divider.
// The block is not ready while an item is in flight or its result waits on m_tready.
module cylindrical_sor_node_relax (
  input  logic                        clk,
  input  logic                        rst,
  // config write port
  input  logic                        cfg_we,
  input  logic [csor_pkg::CIDX_W-1:0] cfg_index,
  input  logic [csor_pkg::CFG_W-1:0]  cfg_data,
  // input items
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // node_index, keep_clamped, potential_value, impurity_value, radius_value,
  // inner_gap, outer_gap, lower_gap, upper_gap, fixed_flag (lowest bit up)
  input  logic [csor_pkg::IN_W-1:0]   s_tdata,
  // req_type
  input  logic [1:0]                  s_tuser,
  // result items
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // node_potential, depleted, overflow (lowest bit up)
  output logic [csor_pkg::OUT_W-1:0]  m_tdata
);
  import csor_pkg::*;

  `include "cylindrical_sor_node_relax_defines.svh"

  // input field offsets within tdata
  localparam int OFF_KEEP = IDX_W;
  localparam int OFF_POT  = OFF_KEEP + 1;
  localparam int OFF_IMP  = OFF_POT + VW;
  localparam int OFF_RAD  = OFF_IMP + VW;
  localparam int OFF_DRM  = OFF_RAD + VW;
  localparam int OFF_DRP  = OFF_DRM + VW - 1;
  localparam int OFF_DZM  = OFF_DRP + VW - 1;
  localparam int OFF_DZP  = OFF_DZM + VW - 1;
  localparam int OFF_FIX  = OFF_DZP + VW - 1;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_LOOK  = 11'b00000000100,
    S_OWN   = 11'b00000001000,
    S_COL   = 11'b00000010000,
    S_NBR   = 11'b00000100000,
    S_RUN   = 11'b00001000000,
    S_WAIT  = 11'b00010000000,
    S_CLAMP = 11'b00100000000,
    S_STORE = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic          fixed;
    logic [VW-2:0] dzp;
    logic [VW-2:0] dzm;
    logic [VW-2:0] drp;
    logic [VW-2:0] drm;
    logic [VW-1:0] rad;
    logic [VW-1:0] imp;
  } node_t;

  state_t state;

  // configuration registers
  logic [CNT_W-1:0] grid_columns, grid_nodes;
  logic [VW-1:0]    density_scale;
  logic [RF_W-1:0]  relax_factor;
  logic [CNT_W-1:0] cols_eff, nodes_eff;

  // latched item control
  logic [1:0]       req;
  logic [IDX_W-1:0] idx;
  logic             keep;

  // memories
  logic [VW-1:0] pot_mem [NODES];
  node_t         node_mem [NODES];
  logic          dep_mem [NODES];
  logic [VW-1:0] pot_rd;
  node_t         node_rd;
  logic          dep_rd;
  logic          pot_we, dep_we, node_we;
  logic [IDX_W-1:0] pot_waddr, pot_raddr, dep_waddr;
  logic [VW-1:0] pot_wdata;
  logic          dep_wdata;
  node_t         node_wdata;

  logic [IDX_W-1:0] clr_cnt;

  // column search and neighbor gather
  logic [IDX_W-1:0] col_rem;
  logic [IDX_W:0]   col_sh;
  logic [3:0]       bit_cnt;
  logic [2:0]       nb;
  logic             has_zm, has_zp, has_rm, has_rp, nb_has;
  logic [IDX_W-1:0] nb_addr;

  // working values
  logic [VW-1:0] own, prm, prp, pzm, pzp;
  logic [VW-1:0] sr, sz, acc, den, xr, yr, er, res_val;
  logic [VW-1:0] lo, hi, lo_a, lo_b, hi_a, hi_b;
  logic          dep_new, sat_acc;
  logic [STEP_W-1:0] step;
  step_t         cur;

  // shared unit
  alu_ctl_t      alu_ctl;
  alu_stat_t     alu_st;
  logic [VW-1:0] alu_a, alu_b, alu_y;

  // result register
  logic [VW-1:0] out_pot;
  logic          out_dep, out_ovf;

  logic s_accept, relax_go;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign s_accept = s_tvalid && s_tready;
  assign m_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, out_ovf, out_dep, out_pot};

  // a zero geometry register is taken as one, and an oversized node count as the full grid
  assign cols_eff  = (grid_columns == '0) ? CNT_W'(1) : grid_columns;
  assign nodes_eff = (grid_nodes == '0) ? CNT_W'(1) :
                     (grid_nodes > CNT_W'(NODES)) ? CNT_W'(NODES) : grid_nodes;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns  <= CNT_W'(64);
      grid_nodes    <= CNT_W'(NODES);
      density_scale <= '0;
      relax_factor  <= RF_W'(7) << (FB - 2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS: grid_columns  <= cfg_data[CNT_W-1:0];
        CFG_NODES:   grid_nodes    <= cfg_data[CNT_W-1:0];
        CFG_DENSITY: density_scale <= cfg_data[VW-1:0];
        CFG_RELAX:   relax_factor  <= cfg_data[RF_W-1:0];
        default:     grid_columns  <= grid_columns;
      endcase
    end
  end

  // node write happens on the accept edge of a write item
  assign node_we    = s_accept && (s_tuser == REQ_WRITE);
  assign node_wdata = '{fixed: s_tdata[OFF_FIX],
                        dzp:   s_tdata[OFF_DZP +: VW-1],
                        dzm:   s_tdata[OFF_DZM +: VW-1],
                        drp:   s_tdata[OFF_DRP +: VW-1],
                        drm:   s_tdata[OFF_DRM +: VW-1],
                        rad:   s_tdata[OFF_RAD +: VW],
                        imp:   s_tdata[OFF_IMP +: VW]};

  assign pot_we    = node_we || (state == S_STORE);
  assign pot_waddr = node_we ? s_tdata[IDX_W-1:0] : idx;
  assign pot_wdata = node_we ? s_tdata[OFF_POT +: VW] : res_val;
  assign pot_raddr = (state == S_NBR) ? nb_addr : idx;

  assign dep_we    = (state == S_CLEAR) || (state == S_STORE);
  assign dep_waddr = (state == S_CLEAR) ? clr_cnt : idx;
  assign dep_wdata = (state == S_CLEAR) ? 1'b0 : dep_new;

  always_ff @(posedge clk) begin
    if (pot_we) begin
      pot_mem[pot_waddr] <= pot_wdata;
    end
    pot_rd <= pot_mem[pot_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[s_tdata[IDX_W-1:0]] <= node_wdata;
    end
    node_rd <= node_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[dep_waddr] <= dep_wdata;
    end
    dep_rd <= dep_mem[idx];
  end

  // neighbor presence from row position and grid size
  assign has_zm = {1'b0, idx} >= cols_eff;
  assign has_zp = ({2'b0, idx} + {1'b0, cols_eff}) < {1'b0, nodes_eff};
  assign has_rm = col_rem != '0;
  assign has_rp = ({1'b0, col_rem} != (cols_eff - 1'b1)) &&
                  (({1'b0, idx} + 1'b1) < nodes_eff);

  // neighbor order: z minus, z plus, r minus, r plus
  always_comb begin
    case (nb[1:0])
      2'd0:    nb_addr = idx - cols_eff[IDX_W-1:0];
      2'd1:    nb_addr = idx + cols_eff[IDX_W-1:0];
      2'd2:    nb_addr = idx - 1'b1;
      default: nb_addr = idx + 1'b1;
    endcase
    case (nb[1:0] - 1'b1)
      2'd0:    nb_has = has_zm;
      2'd1:    nb_has = has_zp;
      2'd2:    nb_has = has_rm;
      default: nb_has = has_rp;
    endcase
  end

  assign col_sh   = {col_rem, idx[bit_cnt]};
  assign relax_go = (req == REQ_RELAX) && ({1'b0, idx} < nodes_eff) && !node_rd.fixed;

  // operand selection for the current program step
  function automatic logic [VW-1:0] src_val(input src_t s);
    logic [VW-1:0] v;
    case (s)
      SRC_OWN: v = own;
      SRC_PRM: v = prm;
      SRC_PRP: v = prp;
      SRC_PZM: v = pzm;
      SRC_PZP: v = pzp;
      SRC_DRM: v = {1'b0, node_rd.drm};
      SRC_DRP: v = {1'b0, node_rd.drp};
      SRC_DZM: v = {1'b0, node_rd.dzm};
      SRC_DZP: v = {1'b0, node_rd.dzp};
      SRC_IMP: v = node_rd.imp;
      SRC_RAD: v = node_rd.rad;
      SRC_ONE: v = VW'(1) << FB;
      SRC_DS:  v = density_scale;
      SRC_RF:  v = VW'(relax_factor);
      SRC_SR:  v = sr;
      SRC_SZ:  v = sz;
      SRC_ACC: v = acc;
      SRC_DEN: v = den;
      SRC_X:   v = xr;
      SRC_Y:   v = yr;
      SRC_E:   v = er;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign cur     = step_rom(step);
  assign alu_ctl = '{start: (state == S_RUN), op: cur.op};

  // operands follow the working registers as well as the step
  always_comb begin
    alu_a = src_val(cur.a);
    alu_b = src_val(cur.b);
  end

  csor_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .a      (alu_a),
    .b      (alu_b),
    .stat   (alu_st),
    .result (alu_y)
  );

  // neighbor range for the clamp
  assign lo_a = ($signed(prp) < $signed(prm)) ? prp : prm;
  assign lo_b = ($signed(pzm) < $signed(pzp)) ? pzm : pzp;
  assign lo   = ($signed(lo_b) < $signed(lo_a)) ? lo_b : lo_a;
  assign hi_a = ($signed(prp) > $signed(prm)) ? prp : prm;
  assign hi_b = ($signed(pzm) > $signed(pzp)) ? pzm : pzp;
  assign hi   = ($signed(hi_b) > $signed(hi_a)) ? hi_b : hi_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_accept) begin
            req   <= s_tuser;
            idx   <= s_tdata[IDX_W-1:0];
            keep  <= s_tdata[OFF_KEEP];
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_OWN;
        end
        S_OWN: begin
          own <= pot_rd;
          if (relax_go) begin
            col_rem <= '0;
            bit_cnt <= 4'(IDX_W - 1);
            state   <= S_COL;
          end else begin
            out_pot <= pot_rd;
            out_dep <= dep_rd;
            out_ovf <= 1'b0;
            state   <= S_OUT;
          end
        end
        S_COL: begin
          // restoring remainder of the node index by the row length
          col_rem <= (col_sh >= cols_eff) ? IDX_W'(col_sh - cols_eff) : col_sh[IDX_W-1:0];
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            nb    <= '0;
            state <= S_NBR;
          end
        end
        S_NBR: begin
          nb <= nb + 1'b1;
          if (nb != '0) begin
            case (nb[1:0] - 1'b1)
              2'd0:    pzm <= nb_has ? pot_rd : own;
              2'd1:    pzp <= nb_has ? pot_rd : own;
              2'd2:    prm <= nb_has ? pot_rd : own;
              default: prp <= nb_has ? pot_rd : own;
            endcase
          end
          if (nb[2]) begin
            step    <= '0;
            sat_acc <= 1'b0;
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_st.done) begin
            sat_acc <= sat_acc | alu_st.sat;
            case (cur.dst)
              DST_SR:  sr      <= alu_y;
              DST_SZ:  sz      <= alu_y;
              DST_ACC: acc     <= alu_y;
              DST_DEN: den     <= alu_y;
              DST_X:   xr      <= alu_y;
              DST_Y:   yr      <= alu_y;
              DST_E:   er      <= alu_y;
              default: res_val <= alu_y;
            endcase
            if (step == STEP_EST) begin
              state <= S_CLAMP;
            end else if (step == STEP_LAST) begin
              state <= S_STORE;
            end else begin
              step  <= step + 1'b1;
              state <= S_RUN;
            end
          end
        end
        S_CLAMP: begin
          if ($signed(er) < $signed(lo)) begin
            res_val <= lo;
            dep_new <= 1'b0;
            state   <= keep ? S_STORE : S_RUN;
          end else if ($signed(er) > $signed(hi)) begin
            res_val <= hi;
            dep_new <= 1'b0;
            state   <= keep ? S_STORE : S_RUN;
          end else begin
            dep_new <= 1'b1;
            state   <= S_RUN;
          end
          step <= STEP_RELAX;
        end
        S_STORE: begin
          out_pot <= res_val;
          out_dep <= dep_new;
          out_ovf <= sat_acc;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `CSOR_ASSERT_NOW(a_one_in_flight, m_tvalid, !s_tready, "input taken while result pending")
  `CSOR_ASSERT_NOW(a_start_idle, alu_ctl.start, !alu_st.busy, "unit started while busy")
  `CSOR_ASSERT_NEXT(a_store_shows, state == S_STORE, m_tvalid, "stored result not shown")
  `CSOR_ASSERT_NOW(a_clear_closed, state == S_CLEAR, !s_tready, "item taken during clear")

endmodule

// ===== sim/tb_top.sv =====
// testbench for the cylindrical r-z relaxation node engine
`timescale 1ns / 1ps
// Drives write, relax and read items through the stream port under several grid
// settings, predicts each result with an independent fixed-point model of the
// node update, and compares every result field by field in arrival order.
module tb_top;
  import csor_pkg::*;

  localparam longint VMAX = (64'sd1 <<< 47) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam longint SMAX = (64'sd1 <<< 47) - 1;  // largest spacing
  localparam longint ONE  = 64'sd1 <<< 24;
  localparam int WATCHDOG_LIMIT = 40000;          // reset sweep and slowest relax fit well

  typedef struct {
    logic [1:0] req;
    int         idx;
    bit         keep;
    longint     pot, imp, rad, drm, drp, dzm, dzp;
    bit         fx;
  } node_req_t;

  typedef struct {
    logic [47:0] pot;
    bit          dep;
    bit          ovf;
  } node_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = CFG_COLUMNS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = REQ_WRITE;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  always #4 clk = ~clk;

  cylindrical_sor_node_relax u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predictor state: node stores and register copies
  longint pot_mem[NODES], imp_mem[NODES], rad_mem[NODES];
  longint drm_mem[NODES], drp_mem[NODES], dzm_mem[NODES], dzp_mem[NODES];
  bit     fixed_mem[NODES], dep_mem[NODES], loaded[NODES];
  int     grid_cols = 64, grid_count = 4096;
  longint density = 0, relax_gain = 64'd7 <<< 22;
  bit     sat_hit;

  node_result_t pending_results[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  no_gaps = 1'b0;
  bit  no_stalls = 1'b0;
  int  stall_left = 0;

  // ---------------- saturating fixed-point arithmetic ----------------

  function automatic logic [127:0] mag128(input longint v);
    return {64'd0, (v < 0) ? -v : v};
  endfunction

  // rebuild a signed value from sign and magnitude, saturating to 48 bits
  function automatic longint from_mag(input bit neg, input logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'(VMAX) + 1 : 128'(VMAX);
    if (m > lim) begin
      sat_hit = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint fx_add(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > VMAX) begin sat_hit = 1'b1; return VMAX; end
    if (s < VMIN) begin sat_hit = 1'b1; return VMIN; end
    return s;
  endfunction

  function automatic longint fx_sub(input longint a, input longint b);
    return fx_add(a, -b);  // operands stay within 48 bits so -b is exact
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] p;
    p = (mag128(a) * mag128(b)) >> 24;
    return from_mag((a < 0) != (b < 0), p);
  endfunction

  // zero dividend gives zero, zero divisor saturates with the dividend's sign
  function automatic longint fx_div(input longint a, input longint b);
    logic [127:0] q;
    if (a == 0) return 0;
    if (b == 0) begin
      sat_hit = 1'b1;
      return (a < 0) ? VMIN : VMAX;
    end
    q = (mag128(a) << 24) / mag128(b);
    return from_mag((a < 0) != (b < 0), q);
  endfunction

  function automatic int eff_cols();
    return (grid_cols == 0) ? 1 : grid_cols;
  endfunction

  function automatic int eff_nodes();
    if (grid_count == 0) return 1;
    return (grid_count > NODES) ? NODES : grid_count;
  endfunction

  // five-point estimate with clamp and optional over-relaxation
  function automatic longint relax_estimate(input int idx, input bit keep, output bit dep);
    int cols, n;
    longint own, pzm, pzp, prm, prp, sr, sz, t0, t1, t2, t3, d1, d2, num, den, e;
    longint lo, hi, res;
    cols = eff_cols();
    n    = eff_nodes();
    own  = pot_mem[idx];
    pzm  = (idx >= cols) ? pot_mem[idx - cols] : own;
    pzp  = (idx + cols >= n) ? own : pot_mem[idx + cols];
    prm  = (idx % cols == 0) ? own : pot_mem[idx - 1];
    prp  = (idx % cols == cols - 1 || idx + 1 >= n) ? own : pot_mem[idx + 1];
    sr = fx_add(drm_mem[idx], drp_mem[idx]);
    sz = fx_add(dzm_mem[idx], dzp_mem[idx]);
    t0 = fx_mul(density, imp_mem[idx]);
    t1 = fx_div(fx_div(fx_sub(prp, prm), sr), rad_mem[idx]);
    t2 = fx_add(fx_div(prp, drp_mem[idx]), fx_div(prm, drm_mem[idx]));
    t2 = fx_div(fx_add(t2, t2), sr);
    t3 = fx_add(fx_div(pzp, dzp_mem[idx]), fx_div(pzm, dzm_mem[idx]));
    t3 = fx_div(fx_add(t3, t3), sz);
    d1 = fx_add(fx_div(ONE, drm_mem[idx]), fx_div(ONE, drp_mem[idx]));
    d1 = fx_div(fx_add(d1, d1), sr);
    d2 = fx_add(fx_div(ONE, dzp_mem[idx]), fx_div(ONE, dzm_mem[idx]));
    d2 = fx_div(fx_add(d2, d2), sz);
    num = fx_add(fx_add(fx_add(t0, t1), t2), t3);
    den = fx_add(d1, d2);
    e   = fx_div(num, den);
    lo = prm; hi = prm;
    if (prp < lo) lo = prp;
    if (pzp < lo) lo = pzp;
    if (pzm < lo) lo = pzm;
    if (prp > hi) hi = prp;
    if (pzp > hi) hi = pzp;
    if (pzm > hi) hi = pzm;
    dep = 1'b1;
    res = own;
    if (e < lo) begin res = lo; dep = 1'b0; end
    else if (e > hi) begin res = hi; dep = 1'b0; end
    if (dep || !keep) res = fx_add(fx_mul(relax_gain, fx_sub(e, own)), own);
    return res;
  endfunction

  // update the node stores for one accepted item and return its result
  function automatic node_result_t predict_node_result(input node_req_t r);
    node_result_t o;
    bit dep;
    longint v;
    o.ovf = 1'b0;
    if (r.req == REQ_WRITE) begin
      pot_mem[r.idx] = r.pot; imp_mem[r.idx] = r.imp; rad_mem[r.idx] = r.rad;
      drm_mem[r.idx] = r.drm; drp_mem[r.idx] = r.drp;
      dzm_mem[r.idx] = r.dzm; dzp_mem[r.idx] = r.dzp;
      fixed_mem[r.idx] = r.fx;
      loaded[r.idx] = 1'b1;
    end else if (r.req == REQ_RELAX && r.idx < eff_nodes() && !fixed_mem[r.idx]) begin
      sat_hit = 1'b0;
      v = relax_estimate(r.idx, r.keep, dep);
      pot_mem[r.idx] = v;
      dep_mem[r.idx] = dep;
      o.ovf = sat_hit;
    end
    o.pot = pot_mem[r.idx][47:0];
    o.dep = dep_mem[r.idx];
    return o;
  endfunction

  // first node this item would read that was never loaded, or -1
  function automatic int first_unloaded(input int idx, input bit relax);
    int cols, n;
    cols = eff_cols();
    n    = eff_nodes();
    if (!loaded[idx]) return idx;
    if (!relax || idx >= n || fixed_mem[idx]) return -1;
    if (idx >= cols && !loaded[idx - cols]) return idx - cols;
    if (idx + cols < n && !loaded[idx + cols]) return idx + cols;
    if (idx % cols != 0 && !loaded[idx - 1]) return idx - 1;
    if (idx % cols != cols - 1 && idx + 1 < n && !loaded[idx + 1]) return idx + 1;
    return -1;
  endfunction

  // ---------------- random field values ----------------

  function automatic longint rand_value();
    logic [47:0] v;
    case ($urandom_range(0, 9))
      0: return VMAX;
      1: return VMIN;
      2: return 0;
      3, 4: v = 48'({$urandom, $urandom});
      default: begin
        v = 48'($urandom_range(0, 1 << 28));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return {{16{v[47]}}, v};
  endfunction

  function automatic longint rand_spacing();
    logic [46:0] v;
    case ($urandom_range(0, 19))
      0: return 1;
      1: return SMAX;
      2: return 0;
      3, 4: begin
        v = 47'({$urandom, $urandom});
        return {17'd0, v};
      end
      default: return $urandom_range(1 << 22, 1 << 26);
    endcase
  endfunction

  function automatic longint rand_radius();
    if ($urandom_range(0, 9) < 2) return rand_value();
    return $urandom_range(1 << 20, 1 << 30);
  endfunction

  function automatic node_req_t node_load(input int idx);
    node_req_t r;
    r.req = REQ_WRITE;
    r.idx = idx;
    r.keep = 1'($urandom_range(0, 1));
    r.pot = rand_value(); r.imp = rand_value(); r.rad = rand_radius();
    r.drm = rand_spacing(); r.drp = rand_spacing();
    r.dzm = rand_spacing(); r.dzp = rand_spacing();
    r.fx = ($urandom_range(0, 99) < 15);
    return r;
  endfunction

  function automatic int gap_len();
    int k;
    if (no_gaps) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------- driver ----------------

  task automatic send_item(input node_req_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.req;
    s_tdata  <= {6'd0, r.fx, r.dzp[46:0], r.dzm[46:0], r.drp[46:0], r.drm[46:0],
                 r.rad[47:0], r.imp[47:0], r.pot[47:0], r.keep, r.idx[11:0]};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_node_result(r));
  endtask

  task automatic send_access(input logic [1:0] req, input int idx, input bit keep);
    node_req_t r;
    r = node_load(idx);  // payload is ignored by the block but still random
    r.req = req;
    r.keep = keep;
    send_item(r);
  endtask

  // let every outstanding result drain before touching a register
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] index, input longint value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[47:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_COLUMNS: grid_cols = int'(value & 64'h1FFF);
      CFG_NODES:   grid_count = int'(value & 64'h1FFF);
      CFG_DENSITY: density = {{16{value[47]}}, value[47:0]};
      CFG_RELAX:   relax_gain = value & 64'h3FF_FFFF;
      default: ;
    endcase
  endtask

  task automatic set_grid(input int cols, input int nodes, input longint dens,
                          input longint gain);
    wait_drained();
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_NODES, nodes);
    write_reg(CFG_DENSITY, dens);
    write_reg(CFG_RELAX, gain);
  endtask

  // random mix over a sliding window; reads and relaxes that would touch an unloaded
  // node become a load of that node instead
  task automatic run_mix(input int count);
    int base, idx, k, miss;
    logic [1:0] req;
    base = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) base = $urandom_range(0, NODES - 16);
      idx = base + $urandom_range(0, 15);
      k = $urandom_range(0, 99);
      if (k < 30) req = REQ_WRITE;
      else if (k < 72) req = REQ_RELAX;
      else req = $urandom_range(0, 1) ? REQ_READ : REQ_READ_ALT;
      if (req == REQ_WRITE) begin
        send_item(node_load(idx));
      end else begin
        miss = first_unloaded(idx, req == REQ_RELAX);
        if (miss >= 0) send_item(node_load(miss));
        else send_access(req, idx, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ---------------- tests ----------------

  // small 3 x 2 grid: corners, edges, extremes, fixed and beyond-grid nodes
  task automatic test_directed();
    node_req_t r;
    set_grid(3, 6, ONE, 64'd7 <<< 22);
    for (int i = 0; i < 6; i++) begin
      r = node_load(i);
      r.fx = 1'b0;
      r.drm = ONE; r.drp = ONE; r.dzm = ONE; r.dzp = 2 * ONE; r.rad = ONE;
      case (i)
        0: r.pot = VMAX;
        1: r.pot = VMIN;
        2: begin r.pot = 0; r.rad = 0; end
        3: begin r.drm = 0; r.dzp = SMAX; end
        4: r.fx = 1'b1;
        default: r.drp = 1;
      endcase
      send_item(r);
    end
    r = node_load(NODES - 1);
    r.fx = 1'b0;
    send_item(r);
    for (int i = 0; i < 6; i++) send_access(REQ_RELAX, i, i[0]);
    send_access(REQ_RELAX, NODES - 1, 1'b0);
    send_access(REQ_RELAX, 0, 1'b1);
    send_access(REQ_RELAX, 5, 1'b0);
    send_access(REQ_READ, 1, 1'b0);
    send_access(REQ_READ_ALT, 4, 1'b1);
    send_access(REQ_READ, NODES - 1, 1'b0);
  endtask

  task automatic test_default_grid();
    no_gaps = 1'b1; no_stalls = 1'b1;
    set_grid(64, 4096, 64'sd3 <<< 23, 64'd7 <<< 22);
    run_mix(180);
    no_gaps = 1'b0; no_stalls = 1'b0;
  endtask

  task automatic test_single_column();
    set_grid(0, 40, -(64'sd1 <<< 24), 0);
    run_mix(240);
  endtask

  task automatic test_wide_rows();
    set_grid(4096, 4096, VMAX, 64'd1 <<< 25);
    run_mix(220);
  endtask

  task automatic test_oversized_registers();
    set_grid(8191, 8191, VMIN, 64'h3FF_FFFF);
    run_mix(220);
  endtask

  task automatic test_tiny_grid();
    set_grid(16, 0, $urandom, 64'd1 <<< 24);
    run_mix(200);
  endtask

  task automatic test_narrow_grid();
    set_grid(8, 64, {$urandom, $urandom}, $urandom_range(0, 1 << 25));
    run_mix(260);
  endtask

  // ---------------- result checker, ready pattern and watchdog ----------------

  always @(posedge clk) begin
    node_result_t exp_r;
    if (!rst) begin
      if (no_stalls) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        stall_left <= $urandom_range(10, 60);
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) < 75);
      end

      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end

      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result item %h", m_tdata);
        end else begin
          exp_r = pending_results.pop_front();
          if (m_tdata[47:0] !== exp_r.pot || m_tdata[48] !== exp_r.dep ||
              m_tdata[49] !== exp_r.ovf) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: potential %h/%h depleted %b/%b overflow %b/%b (exp/act)",
                       exp_r.pot, m_tdata[47:0], exp_r.dep, m_tdata[48],
                       exp_r.ovf, m_tdata[49]);
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_default_grid();
    test_single_column();
    test_wide_rows();
    test_oversized_registers();
    test_tiny_grid();
    test_narrow_grid();
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== cylindrical_sor_node_relax.f =====
+incdir+design
design/csor_pkg.sv
design/csor_alu.sv
design/cylindrical_sor_node_relax.sv
sim/tb_top.sv
